// ----- hdl/ias_pkg.sv -----
// Shared constants, operation codes and controller/datapath link types for the array store.
package ias_pkg;

   // Default storage depth of the entry memory.
   localparam int DEPTH_DEFAULT = 256;

   // Field widths of the request and response items.
   localparam int KIND_W = 3;
   localparam int IDX_W  = 9;
   localparam int CNT_W  = 9;
   localparam int POS_W  = 8;
   localparam int WORD_W = 32;

   // Request operation codes.
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUM    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   // Capacity register value after reset.
   localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic fin;
      logic swap;
      logic load_rsp;
   } ias_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic scan_done;
      logic need_swap;
   } ias_sts_type;

endpackage

// ----- hdl/ias_req_if.sv -----
// Request channel interface: valid/ready handshake with the request item.
interface ias_req_if;
   logic                              valid;
   logic                              ready;
   logic [ias_pkg::KIND_W-1:0]        kind;
   logic [ias_pkg::IDX_W-1:0]         index;
   logic signed [ias_pkg::WORD_W-1:0] value;

   modport source (output valid, kind, index, value, input ready);
   modport sink (input valid, kind, index, value, output ready);
endinterface

// ----- hdl/ias_rsp_if.sv -----
// Response channel interface: valid/ready handshake with the result item.
interface ias_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              status;
   logic                              found;
   logic [ias_pkg::POS_W-1:0]         position;
   logic signed [ias_pkg::WORD_W-1:0] data;
   logic [ias_pkg::CNT_W-1:0]         count;

   modport source (output valid, status, found, position, data, count, input ready);
   modport sink (input valid, status, found, position, data, count, output ready);
endinterface

// ----- hdl/ias_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
module ias_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ias_pkg::ias_cmd_type cmd,
   input  ias_pkg::ias_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_FIN  = 5'b00100,
      ST_SWAP = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The output register can take a new item once the old one is gone or leaving.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = sts.need_swap ? ST_SWAP : ST_DONE;
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid flag: set when a result is loaded, cleared when it is taken.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/ias_dpath.sv -----
// Datapath: entry memory, fill count, capacity register, scan pointers and result register.
module ias_dpath #(
   parameter int DEPTH = ias_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ias_pkg::ias_cmd_type              cmd,
   output ias_pkg::ias_sts_type              sts,
   input  logic [ias_pkg::KIND_W-1:0]        req_kind,
   input  logic [ias_pkg::IDX_W-1:0]         req_index,
   input  logic signed [ias_pkg::WORD_W-1:0] req_value,
   input  logic                              csr_wr_en,
   input  logic [ias_pkg::CNT_W-1:0]         csr_wr_data,
   output logic                              rsp_status,
   output logic                              rsp_found,
   output logic [ias_pkg::POS_W-1:0]         rsp_position,
   output logic signed [ias_pkg::WORD_W-1:0] rsp_data,
   output logic [ias_pkg::CNT_W-1:0]         rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int KW = ias_pkg::KIND_W;
   localparam int CW = ias_pkg::CNT_W;
   localparam int PW = ias_pkg::POS_W;
   localparam int WW = ias_pkg::WORD_W;

   // Entry storage: one write port, one registered read port.
   logic signed [WW-1:0] mem [DEPTH];
   logic signed [WW-1:0] rd_data_ff;
   logic                 rd_en;
   logic                 wr_en;
   logic [CW-1:0]        wr_addr;
   logic signed [WW-1:0] wr_data;

   // Request held for the duration of the operation.
   logic [KW-1:0]        kind_ff;
   logic [CW-1:0]        idx_ff;
   logic signed [WW-1:0] val_ff;
   logic                 ok_ff, ok_in;

   // Scan control.
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        wptr_ff, wptr_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 lag_ff, lag_in;
   logic                 proc_en;

   // Search and accumulation results.
   logic                 hit_ff, hit_in;
   logic [CW-1:0]        hit_idx_ff, hit_idx_in;
   logic signed [WW-1:0] prev_ff, prev_in;
   logic signed [WW-1:0] acc_ff, acc_in;

   // Fill count and capacity.
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        cap_ff;
   logic [CW-1:0]        cap_lim;

   // Result register.
   logic                 rsp_status_ff;
   logic                 rsp_found_ff;
   logic [PW-1:0]        rsp_position_ff;
   logic signed [WW-1:0] rsp_data_ff;
   logic [CW-1:0]        rsp_count_ff;

   // Effective capacity is the register capped at the storage depth.
   assign cap_lim = (32'(cap_ff) > 32'(DEPTH)) ? CW'(DEPTH) : cap_ff;

   // Range check of a new request.
   always_comb begin
      case (req_kind)
         ias_pkg::KIND_INSERT: ok_in = (req_index <= fill_ff) && (fill_ff < cap_lim);
         ias_pkg::KIND_DELETE: ok_in = req_index < fill_ff;
         ias_pkg::KIND_READ:   ok_in = req_index < fill_ff;
         ias_pkg::KIND_SEARCH: ok_in = 1'b1;
         ias_pkg::KIND_SUM:    ok_in = 1'b1;
         default:              ok_in = 1'b0;
      endcase
   end

   // A read is issued each scan cycle while entries remain and no hit stopped the search.
   assign rd_en   = cmd.scan && (rem_ff != '0) && !hit_ff;
   assign proc_en = cmd.scan && lag_ff && !hit_ff;

   // Scan pointers, counters and per-entry processing.
   always_comb begin
      ptr_in     = ptr_ff;
      wptr_in    = wptr_ff;
      rem_in     = rem_ff;
      lag_in     = 1'b0;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      prev_in    = prev_ff;
      acc_in     = acc_ff;
      fill_in    = fill_ff;
      wr_en      = 1'b0;
      wr_addr    = wptr_ff;
      wr_data    = rd_data_ff;

      if (cmd.start) begin
         hit_in = 1'b0;
         acc_in = '0;
         rem_in = '0;
         case (req_kind)
            ias_pkg::KIND_INSERT: begin
               ptr_in  = fill_ff - 1'b1;
               wptr_in = fill_ff;
               if (ok_in) begin
                  rem_in = fill_ff - req_index;
               end
            end
            ias_pkg::KIND_DELETE: begin
               ptr_in  = req_index + 1'b1;
               wptr_in = req_index;
               if (ok_in) begin
                  rem_in = fill_ff - req_index - 1'b1;
               end
            end
            ias_pkg::KIND_READ: begin
               ptr_in  = req_index;
               wptr_in = req_index;
               if (ok_in) begin
                  rem_in = CW'(1);
               end
            end
            default: begin
               // Search and sum walk every stored entry from the front.
               ptr_in  = '0;
               wptr_in = '0;
               if (ok_in) begin
                  rem_in = fill_ff;
               end
            end
         endcase
      end

      if (rd_en) begin
         rem_in = rem_ff - 1'b1;
         lag_in = 1'b1;
         if (kind_ff == ias_pkg::KIND_INSERT) begin
            ptr_in = ptr_ff - 1'b1;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end

      // Handle the entry read in the previous cycle.
      if (proc_en) begin
         case (kind_ff)
            ias_pkg::KIND_INSERT: begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff - 1'b1;
            end
            ias_pkg::KIND_DELETE: begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff + 1'b1;
            end
            ias_pkg::KIND_SEARCH: begin
               if (rd_data_ff == val_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = wptr_ff;
               end else begin
                  prev_in = rd_data_ff;
               end
               wptr_in = wptr_ff + 1'b1;
            end
            ias_pkg::KIND_SUM: begin
               acc_in = acc_ff + rd_data_ff;
            end
            default: begin
               acc_in = rd_data_ff;
            end
         endcase
      end

      // Closing step: place the new word, adjust the count, or start the swap.
      if (cmd.fin && ok_ff) begin
         case (kind_ff)
            ias_pkg::KIND_INSERT: begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = val_ff;
               fill_in = fill_ff + 1'b1;
            end
            ias_pkg::KIND_DELETE: begin
               fill_in = fill_ff - 1'b1;
            end
            ias_pkg::KIND_SEARCH: begin
               if (hit_ff && (hit_idx_ff != '0)) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
                  wr_data = prev_ff;
               end
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end

      // Second half of the transposition: the key moves one place forward.
      if (cmd.swap) begin
         wr_en   = 1'b1;
         wr_addr = hit_idx_ff - 1'b1;
         wr_data = val_ff;
      end
   end

   // Status back to the controller.
   assign sts = '{scan_done: ((rem_ff == '0) && !lag_ff) || hit_ff,
                  need_swap: hit_ff && (hit_idx_ff != '0)};

   // Entry memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(wr_addr)] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[AW'(ptr_ff)];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         lag_ff  <= 1'b0;
         hit_ff  <= 1'b0;
         fill_ff <= '0;
         ok_ff   <= 1'b0;
         cap_ff  <= ias_pkg::CAPACITY_RESET;
      end else begin
         rem_ff  <= rem_in;
         lag_ff  <= lag_in;
         hit_ff  <= hit_in;
         fill_ff <= fill_in;
         if (cmd.start) begin
            ok_ff <= ok_in;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      wptr_ff    <= wptr_in;
      hit_idx_ff <= hit_idx_in;
      prev_ff    <= prev_in;
      acc_ff     <= acc_in;
      if (cmd.start) begin
         kind_ff <= req_kind;
         idx_ff  <= req_index;
         val_ff  <= req_value;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff   <= !ok_ff;
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= hit_ff ? PW'(hit_idx_ff) : '0;
         rsp_data_ff     <= acc_ff;
         rsp_count_ff    <= fill_ff;
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// ----- hdl/indexed_array_store_core.sv -----
// Top level of the indexed array store: controller, datapath and checks.
//
// The block keeps up to DEPTH signed 32-bit entries and a fill count. Items
// arrive on the request channel (kind, index, value) and one result item per
// request leaves on the response channel (status, found, position, data,
// count), both under a valid/ready handshake. The capacity register is
// written through csr_wr_en and csr_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. One request is
// handled at a time. An accepted request passes the scan, closing and done
// states, and the scan walks n entries: the entries shifted by an insert or
// delete, the entries before and at the hit of a search (every stored entry on a
// miss), every stored entry for a sum, and one for a read. A search hit that is
// not at the front adds a swap state that moves it one place forward. The walk
// goes through the single read port of the entry memory at one entry per cycle.
// A new request is taken while an earlier result still waits in the output
// register; its own result waits in the controller until that register frees.
// Reset empties the store and sets the capacity to 256; the memory itself is
// not cleared, as entries at or beyond the fill count are never read.
module indexed_array_store_core #(
   parameter int DEPTH = ias_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   ias_req_if.sink                   req_chan,
   ias_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [ias_pkg::CNT_W-1:0] csr_wr_data
);

   ias_pkg::ias_cmd_type cmd;
   ias_pkg::ias_sts_type sts;

   // Sequencing of each request.
   ias_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Storage, scan and result registers.
   ias_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_kind     (req_chan.kind),
      .req_index    (req_chan.index),
      .req_value    (req_chan.value),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_status   (rsp_chan.status),
      .rsp_found    (rsp_chan.found),
      .rsp_position (rsp_chan.position),
      .rsp_data     (rsp_chan.data),
      .rsp_count    (rsp_chan.count)
   );

   // Once an item is accepted the block stays busy for at least the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_chan.ready)
      else $error("request channel ready straight after an item was accepted");

   // The controller issues at most one command per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.scan, cmd.fin, cmd.swap, cmd.load_rsp}))
      else $error("more than one datapath command in one cycle");

   // A loaded result is presented on the response channel.
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_chan.valid)
      else $error("result loaded but response valid is low");

   // A failed request never reports a search hit.
   a_fail_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> !rsp_chan.found)
      else $error("failed request reports a search hit");

   // The reported fill count never exceeds the storage depth.
   a_count_in_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (32'(rsp_chan.count) <= 32'(DEPTH)))
      else $error("fill count beyond storage depth");

endmodule
